FILE: src/doubly_linked_list_cursor_engine_top_defines.svh
// Assertion macros shared by the cursor engine modules.
`ifndef DOUBLY_LINKED_LIST_CURSOR_ENGINE_TOP_DEFINES_SVH
`define DOUBLY_LINKED_LIST_CURSOR_ENGINE_TOP_DEFINES_SVH

// A condition that holds at every clock edge out of reset.
`define DLC_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// A trigger that must be followed by a condition in the next cycle.
`define DLC_ASSERT_NEXT(label, trig, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
    else $error("assertion failed");

`endif

FILE: src/dlc_pkg.sv
// Shared constants, types and helpers of the cursor engine.
package dlc_pkg;

  localparam int NODE_COUNT  = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int OUT_W       = 32;
  localparam int IDX_W       = $clog2(NODE_COUNT);
  localparam int PTR_W       = $clog2(NODE_COUNT + 1);
  localparam int CNT_W       = PTR_W;
  localparam int CMD_W       = 4;
  localparam int ST_W        = 4;

  localparam logic [PTR_W-1:0] NIL   = PTR_W'(NODE_COUNT);
  localparam logic [CNT_W-1:0] N_CNT = CNT_W'(NODE_COUNT);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd0;
  localparam logic [CMD_W-1:0] CMD_INS_FIRST  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_INS_LAST   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_CUR_FIRST  = 4'd3;
  localparam logic [CMD_W-1:0] CMD_CUR_LAST   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_FIRST  = 4'd5;
  localparam logic [CMD_W-1:0] CMD_DEL_LAST   = 4'd6;
  localparam logic [CMD_W-1:0] CMD_DEL_AFTER  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_DEL_BEFORE = 4'd8;
  localparam logic [CMD_W-1:0] CMD_INS_AFTER  = 4'd9;
  localparam logic [CMD_W-1:0] CMD_INS_BEFORE = 4'd10;
  localparam logic [CMD_W-1:0] CMD_SET_VALUE  = 4'd11;
  localparam logic [CMD_W-1:0] CMD_NEXT       = 4'd12;
  localparam logic [CMD_W-1:0] CMD_PREVIOUS   = 4'd13;

  // Command classes reported to the controller.
  localparam logic [1:0] CLS_OTHER = 2'd0;
  localparam logic [1:0] CLS_INS   = 2'd1;
  localparam logic [1:0] CLS_DEL   = 2'd2;
  localparam logic [1:0] CLS_MOV   = 2'd3;

  // Controller states, also used as the datapath step code.
  localparam logic [ST_W-1:0] S_IDLE = 4'd0;
  localparam logic [ST_W-1:0] S_DEC  = 4'd1;
  localparam logic [ST_W-1:0] S_I1   = 4'd2;
  localparam logic [ST_W-1:0] S_I2   = 4'd3;
  localparam logic [ST_W-1:0] S_I3   = 4'd4;
  localparam logic [ST_W-1:0] S_D1   = 4'd5;
  localparam logic [ST_W-1:0] S_D2   = 4'd6;
  localparam logic [ST_W-1:0] S_D3   = 4'd7;
  localparam logic [ST_W-1:0] S_M1   = 4'd8;
  localparam logic [ST_W-1:0] S_R0   = 4'd9;
  localparam logic [ST_W-1:0] S_R1   = 4'd10;
  localparam logic [ST_W-1:0] S_R2   = 4'd11;
  localparam logic [ST_W-1:0] S_R3   = 4'd12;

  typedef struct packed {
    logic [1:0] cls;
    logic       go;
    logic       full;
    logic       tgt_ok;
  } dp_status_t;

  typedef struct packed {
    logic [ST_W-1:0] step;
    logic            accept;
  } dp_cmd_t;

  function automatic logic signed [OUT_W-1:0] to_out(input logic [VALUE_WIDTH-1:0] v);
    return OUT_W'($signed(v));
  endfunction

endpackage

FILE: src/doubly_linked_list_cursor_engine_top.sv
// Top level of the doubly linked list cursor engine.
//
//  Channel   Handshake              Payload
//  input     start, busy            in_cmd, in_value
//  result    out_valid (strobe)     out_status .. out_node_count
//
// Busy is high from the edge that takes start to the edge that drives the
// result: after decode an insert or delete that changes the list runs I1-I3
// or D1-D3, a delete at an end of an empty list or past an end stops after
// D2, a cursor step runs M1, and every command ends with steps R0-R3. The
// strobe comes in the first cycle with busy low; the receiver cannot stall
// it. Reset is synchronous and leaves an empty list; clear takes no sweep.
module doubly_linked_list_cursor_engine_top import dlc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [CMD_W-1:0]        in_cmd,
  input  logic signed [31:0]      in_value,
  output logic                    out_valid,
  output logic                    out_status,
  output logic                    out_list_empty,
  output logic                    out_cursor_active,
  output logic signed [OUT_W-1:0] out_first_value,
  output logic signed [OUT_W-1:0] out_last_value,
  output logic signed [OUT_W-1:0] out_cursor_value,
  output logic [CNT_W-1:0]        out_node_count
);

  dp_status_t st;
  dp_cmd_t    cmd;

  // The controller walks each item through its steps.
  dlc_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .st, .cmd
  );

  // The datapath holds the list and builds the result item.
  dlc_dp u_dp (
    .clk, .rst_n, .cmd, .in_cmd, .in_value, .st,
    .out_valid, .out_status, .out_list_empty, .out_cursor_active,
    .out_first_value, .out_last_value, .out_cursor_value, .out_node_count
  );

endmodule

FILE: src/dlc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/dlc_ctrl.sv
// Controller state machine that sequences each command through the datapath.
`include "doubly_linked_list_cursor_engine_top_defines.svh"
module dlc_ctrl import dlc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  logic [ST_W-1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_DEC;
      S_DEC: begin
        unique case (st.cls)
          CLS_INS: state_nxt = (st.go && !st.full) ? S_I1 : S_R0;
          CLS_DEL: state_nxt = st.go ? S_D1 : S_R0;
          CLS_MOV: state_nxt = st.go ? S_M1 : S_R0;
          default: state_nxt = S_R0;
        endcase
      end
      S_I1: state_nxt = S_I2;
      S_I2: state_nxt = S_I3;
      S_I3: state_nxt = S_R0;
      S_D1: state_nxt = S_D2;
      S_D2: state_nxt = st.tgt_ok ? S_D3 : S_R0;
      S_D3: state_nxt = S_R0;
      S_M1: state_nxt = S_R0;
      S_R0: state_nxt = S_R1;
      S_R1: state_nxt = S_R2;
      S_R2: state_nxt = S_R3;
      S_R3: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign cmd.step   = state_r;
  assign cmd.accept = start && (state_r == S_IDLE);

  `DLC_ASSERT_NEXT(a_start_decodes, start && !busy, state_r == S_DEC)
  `DLC_ASSERT_NEXT(a_r3_returns, state_r == S_R3, state_r == S_IDLE)

endmodule

FILE: src/dlc_dp.sv
// Datapath: pointers, free pool, node memories and result registers.
`include "doubly_linked_list_cursor_engine_top_defines.svh"
module dlc_dp import dlc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  input  logic [CMD_W-1:0]        in_cmd,
  input  logic signed [31:0]      in_value,
  output dp_status_t              st,
  output logic                    out_valid,
  output logic                    out_status,
  output logic                    out_list_empty,
  output logic                    out_cursor_active,
  output logic signed [OUT_W-1:0] out_first_value,
  output logic signed [OUT_W-1:0] out_last_value,
  output logic signed [OUT_W-1:0] out_cursor_value,
  output logic [CNT_W-1:0]        out_node_count
);

  logic [CMD_W-1:0]       cmd_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [PTR_W-1:0]       head_r, tail_r, cur_r, t_r, n_r, p_r, q_r;
  logic [CNT_W-1:0]       rc_r, fi_r;
  logic                   status_r, valid_r;

  logic                   val_we, nxt_we, prv_we, stk_we;
  logic [IDX_W-1:0]       val_wa, nxt_wa, prv_wa, stk_wa, val_ra, link_ra, stk_ra;
  logic [VALUE_WIDTH-1:0] val_wd, val_rd;
  logic [PTR_W-1:0]       nxt_wd, prv_wd, nxt_rd, prv_rd;
  logic [IDX_W-1:0]       stk_rd;
  logic [CNT_W-1:0]       rc_m1;

  logic is_ins, is_del, is_mov, need_cur, cur_ok;

  always_comb begin
    is_ins   = (cmd_r == CMD_INS_FIRST) || (cmd_r == CMD_INS_LAST) ||
               (cmd_r == CMD_INS_AFTER) || (cmd_r == CMD_INS_BEFORE);
    is_del   = (cmd_r == CMD_DEL_FIRST) || (cmd_r == CMD_DEL_LAST) ||
               (cmd_r == CMD_DEL_AFTER) || (cmd_r == CMD_DEL_BEFORE);
    is_mov   = (cmd_r == CMD_NEXT) || (cmd_r == CMD_PREVIOUS);
    need_cur = (cmd_r == CMD_DEL_AFTER) || (cmd_r == CMD_DEL_BEFORE) ||
               (cmd_r == CMD_INS_AFTER) || (cmd_r == CMD_INS_BEFORE) ||
               (cmd_r == CMD_SET_VALUE) || is_mov;
    cur_ok   = (cur_r < NIL);
    st.cls    = is_ins ? CLS_INS : is_del ? CLS_DEL : is_mov ? CLS_MOV : CLS_OTHER;
    st.go     = !need_cur || cur_ok;
    st.full   = (rc_r == '0) && (fi_r == N_CNT);
    st.tgt_ok = (t_r < NIL);
  end

  assign rc_m1   = rc_r - CNT_W'(1);
  assign stk_ra  = rc_m1[IDX_W-1:0];
  assign link_ra = (cmd.step == S_D2) ? t_r[IDX_W-1:0] : cur_r[IDX_W-1:0];

  // Memory write and read port selection per step.
  always_comb begin
    val_we = 1'b0; val_wa = n_r[IDX_W-1:0]; val_wd = val_r;
    nxt_we = 1'b0; nxt_wa = n_r[IDX_W-1:0]; nxt_wd = q_r;
    prv_we = 1'b0; prv_wa = n_r[IDX_W-1:0]; prv_wd = p_r;
    stk_we = 1'b0; stk_wa = rc_r[IDX_W-1:0];
    val_ra = head_r[IDX_W-1:0];
    unique case (cmd.step)
      S_DEC: begin
        if (cmd_r == CMD_SET_VALUE && cur_ok) begin
          val_we = 1'b1;
          val_wa = cur_r[IDX_W-1:0];
        end
      end
      S_I2: begin
        val_we = 1'b1;
        nxt_we = 1'b1;
        prv_we = 1'b1;
      end
      S_I3: begin
        nxt_we = (p_r < NIL); nxt_wa = p_r[IDX_W-1:0]; nxt_wd = n_r;
        prv_we = (q_r < NIL); prv_wa = q_r[IDX_W-1:0]; prv_wd = n_r;
      end
      S_D3: begin
        nxt_we = (prv_rd < NIL); nxt_wa = prv_rd[IDX_W-1:0]; nxt_wd = nxt_rd;
        prv_we = (nxt_rd < NIL); prv_wa = nxt_rd[IDX_W-1:0]; prv_wd = prv_rd;
        stk_we = 1'b1;
      end
      S_R1: val_ra = tail_r[IDX_W-1:0];
      S_R2: val_ra = cur_r[IDX_W-1:0];
      default: ;
    endcase
  end

  dlc_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(NODE_COUNT)) u_val (
    .clk, .we(val_we), .waddr(val_wa), .wdata(val_wd), .raddr(val_ra), .rdata(val_rd)
  );
  dlc_ram #(.WIDTH(PTR_W), .DEPTH(NODE_COUNT)) u_nxt (
    .clk, .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd), .raddr(link_ra), .rdata(nxt_rd)
  );
  dlc_ram #(.WIDTH(PTR_W), .DEPTH(NODE_COUNT)) u_prv (
    .clk, .we(prv_we), .waddr(prv_wa), .wdata(prv_wd), .raddr(link_ra), .rdata(prv_rd)
  );
  dlc_ram #(.WIDTH(IDX_W), .DEPTH(NODE_COUNT)) u_stk (
    .clk, .we(stk_we), .waddr(stk_wa), .wdata(t_r[IDX_W-1:0]), .raddr(stk_ra),
    .rdata(stk_rd)
  );

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r <= in_cmd;
      val_r <= VALUE_WIDTH'(in_value);
    end
    unique case (cmd.step)
      S_DEC: begin
        if (cmd_r == CMD_DEL_FIRST) t_r <= head_r;
        else t_r <= tail_r;
      end
      S_D1: begin
        if (cmd_r == CMD_DEL_AFTER) t_r <= nxt_rd;
        else if (cmd_r == CMD_DEL_BEFORE) t_r <= prv_rd;
      end
      S_I1: begin
        n_r <= (rc_r != '0) ? PTR_W'(stk_rd) : fi_r;
        unique case (cmd_r)
          CMD_INS_FIRST: begin p_r <= NIL;    q_r <= head_r; end
          CMD_INS_LAST:  begin p_r <= tail_r; q_r <= NIL;    end
          CMD_INS_AFTER: begin p_r <= cur_r;  q_r <= nxt_rd; end
          default:       begin p_r <= prv_rd; q_r <= cur_r;  end
        endcase
      end
      S_R1: out_first_value  <= (head_r < NIL) ? to_out(val_rd) : '0;
      S_R2: out_last_value   <= (tail_r < NIL) ? to_out(val_rd) : '0;
      S_R3: begin
        out_cursor_value  <= (cur_r < NIL) ? to_out(val_rd) : '0;
        out_list_empty    <= (head_r == NIL);
        out_cursor_active <= (cur_r < NIL);
        out_node_count    <= fi_r - rc_r;
        out_status        <= status_r;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= NIL; tail_r <= NIL; cur_r <= NIL;
      rc_r <= '0; fi_r <= '0;
      status_r <= 1'b0; valid_r <= 1'b0;
    end else begin
      valid_r <= (cmd.step == S_R3);
      if (cmd.accept) status_r <= 1'b0;
      unique case (cmd.step)
        S_DEC: begin
          unique case (cmd_r)
            CMD_CLEAR: begin
              head_r <= NIL; tail_r <= NIL; cur_r <= NIL;
              rc_r <= '0; fi_r <= '0;
            end
            CMD_CUR_FIRST: cur_r <= head_r;
            CMD_CUR_LAST:  cur_r <= tail_r;
            default: if (is_ins && st.go && st.full) status_r <= 1'b1;
          endcase
        end
        S_I1: begin
          if (rc_r != '0) rc_r <= rc_m1;
          else fi_r <= fi_r + CNT_W'(1);
        end
        S_I3: begin
          if (!(p_r < NIL)) head_r <= n_r;
          if (!(q_r < NIL)) tail_r <= n_r;
        end
        S_D3: begin
          if (!(prv_rd < NIL)) head_r <= nxt_rd;
          if (!(nxt_rd < NIL)) tail_r <= prv_rd;
          if (cur_r == t_r) cur_r <= NIL;
          rc_r <= rc_r + CNT_W'(1);
        end
        S_M1: cur_r <= (cmd_r == CMD_NEXT) ? nxt_rd : prv_rd;
        default: ;
      endcase
    end
  end

  assign out_valid = valid_r;

  `DLC_ASSERT(a_pool_bound, (rc_r <= fi_r) && (fi_r <= N_CNT))
  `DLC_ASSERT(a_ends_agree, (head_r == NIL) == (tail_r == NIL))
  `DLC_ASSERT_NEXT(a_strobe_once, valid_r, !valid_r)

endmodule
